FILE: sv/tad_pkg.sv
package tad_pkg;

    localparam int ACCEL_W = 16;
    localparam int CFG_W   = 16;
    localparam int ADDR_W  = 3;
    localparam int SQ_W    = 32;
    localparam int ROOT_W  = 16;
    localparam int DOT_W   = 34;
    localparam int DUTY_W  = 10;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 10'd1000;
    localparam int                DUTY_SCALE = 1000;

    localparam logic [CFG_W-1:0] MIN_MAG_RST   = 16'd0;
    localparam logic [CFG_W-1:0] MAX_MAG_RST   = 16'd56756;
    localparam logic [CFG_W-1:0] REF_X_RST     = 16'd0;
    localparam logic [CFG_W-1:0] REF_Y_RST     = 16'd0;
    localparam logic [CFG_W-1:0] REF_Z_RST     = 16'd16384;
    localparam logic [CFG_W-1:0] MIN_ALIGN_RST = 16'd14746;

    typedef enum logic [ADDR_W-1:0] {
        CFG_MIN_MAG   = 3'd0,
        CFG_MAX_MAG   = 3'd1,
        CFG_REF_X     = 3'd2,
        CFG_REF_Y     = 3'd3,
        CFG_REF_Z     = 3'd4,
        CFG_MIN_ALIGN = 3'd5
    } t_cfg_idx;

    // sideband carried through the root pipeline
    typedef struct packed {
        logic                    ok;
        logic signed [DOT_W-1:0] dot;
    } t_root_side;

endpackage

FILE: sv/tad_isqrt.sv
module tad_isqrt #(
    parameter int SW = 35
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [tad_pkg::SQ_W-1:0]   i_rad,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [tad_pkg::ROOT_W-1:0] o_root,
    output logic [SW-1:0]              o_side
);
    import tad_pkg::*;

    logic [SQ_W-1:0]   w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] w_root [0:ROOT_W];
    logic [SW-1:0]     w_side [0:ROOT_W];
    logic              w_v    [0:ROOT_W];

    assign w_rem[0]  = i_rad;
    assign w_root[0] = '0;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    // one result bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W+1:0]   t;
        logic              ge;
        logic [SQ_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [SQ_W-1:0]   r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [SW-1:0]     r_side;
        logic              r_v;

        always_comb begin
            t      = ({{(SQ_W+2-ROOT_W){1'b0}}, w_root[k]} << (B + 1))
                     + ((SQ_W+2)'(1) << (2 * B));
            ge     = {2'b00, w_rem[k]} >= t;
            n_rem  = ge ? (w_rem[k] - t[SQ_W-1:0]) : w_rem[k];
            n_root = ge ? (w_root[k] | (ROOT_W'(1) << B)) : w_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_side[k+1] = r_side;
        assign w_v[k+1]    = r_v;
    end

    assign o_valid = w_v[ROOT_W];
    assign o_root  = w_root[ROOT_W];
    assign o_side  = w_side[ROOT_W];

endmodule

FILE: sv/tad_div.sv
module tad_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 15,
    parameter int SW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);
    localparam int XW = NW + QW;

    logic [NW-1:0] w_rem  [0:QW];
    logic [QW-1:0] w_quot [0:QW];
    logic [DW-1:0] w_den  [0:QW];
    logic          w_ovf  [0:QW];
    logic [SW-1:0] w_side [0:QW];
    logic          w_v    [0:QW];

    logic [NW-1:0] r_rem0;
    logic [DW-1:0] r_den0;
    logic          r_ovf0;
    logic [SW-1:0] r_side0;
    logic          r_v0;

    // flag a quotient that does not fit in QW bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0  <= i_num;
            r_den0  <= i_den;
            r_ovf0  <= (i_num >> QW) >= NW'(i_den);
            r_side0 <= i_side;
        end
    end

    assign w_rem[0]  = r_rem0;
    assign w_quot[0] = '0;
    assign w_den[0]  = r_den0;
    assign w_ovf[0]  = r_ovf0;
    assign w_side[0] = r_side0;
    assign w_v[0]    = r_v0;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [XW-1:0] t;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quot;
        logic [NW-1:0] r_rem;
        logic [QW-1:0] r_quot;
        logic [DW-1:0] r_den;
        logic          r_ovf;
        logic [SW-1:0] r_side;
        logic          r_v;

        always_comb begin
            t      = XW'(w_den[k]) << B;
            ge     = XW'(w_rem[k]) >= t;
            n_rem  = ge ? (w_rem[k] - t[NW-1:0]) : w_rem[k];
            n_quot = ge ? (w_quot[k] | (QW'(1) << B)) : w_quot[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_quot <= n_quot;
                r_den  <= w_den[k];
                r_ovf  <= w_ovf[k];
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_quot[k+1] = r_quot;
        assign w_den[k+1]  = r_den;
        assign w_ovf[k+1]  = r_ovf;
        assign w_side[k+1] = r_side;
        assign w_v[k+1]    = r_v;
    end

    assign o_valid = w_v[QW];
    assign o_quot  = w_quot[QW];
    assign o_ovf   = w_ovf[QW];
    assign o_side  = w_side[QW];

endmodule

FILE: sv/tilt_alignment_to_duty.sv
// Pipeline from input transaction to result valid: products, sums, root unit, alignment divider,
// saturation, offset, scaling, duty divider and output register; a stalled output holds every stage.
// Throughput: one sample per cycle; the root unit and both dividers are fully pipelined,
// one result bit per stage, and the whole pipeline advances whenever the output is free.
// Reset: synchronous active-low i_rst_n clears all valid bits and loads the
// configuration registers with their defaults; data registers are not reset.
module tilt_alignment_to_duty #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tad_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [tad_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
    input  logic [47:0]                 i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [9:0] duty_permille, [25:10] alignment, [26] magnitude_ok, [31:27] zero
    output logic [31:0]                 o_m_axis_tdata
);
    import tad_pkg::*;

    localparam int QW1  = FRAC_BITS + 1;
    localparam int N1W  = 34;
    localparam int D1W  = ROOT_W + 1;
    localparam int AW   = ((FRAC_BITS + 2 > 16) ? FRAC_BITS + 2 : 16) + 1;
    localparam int PW   = AW + 10;
    localparam int N2W  = AW + 12;
    localparam int D2W  = AW + 1;
    localparam int QW2  = DUTY_W;
    localparam int RSW  = $bits(t_root_side);

    localparam logic [QW1-1:0]       ONE_Q = QW1'(1) << FRAC_BITS;
    localparam logic signed [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;

    // configuration
    logic [CFG_W-1:0]        r_min_mag, r_max_mag;
    logic signed [CFG_W-1:0] r_ref_x, r_ref_y, r_ref_z, r_min_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag   <= MIN_MAG_RST;
            r_max_mag   <= MAX_MAG_RST;
            r_ref_x     <= REF_X_RST;
            r_ref_y     <= REF_Y_RST;
            r_ref_z     <= REF_Z_RST;
            r_min_align <= MIN_ALIGN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MIN_MAG:   r_min_mag   <= i_cfg_wdata;
                CFG_MAX_MAG:   r_max_mag   <= i_cfg_wdata;
                CFG_REF_X:     r_ref_x     <= i_cfg_wdata;
                CFG_REF_Y:     r_ref_y     <= i_cfg_wdata;
                CFG_REF_Z:     r_ref_z     <= i_cfg_wdata;
                CFG_MIN_ALIGN: r_min_align <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_out_v;
    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1: products
    logic signed [ACCEL_W-1:0] w_ax, w_ay, w_az;
    assign w_ax = i_s_axis_tdata[15:0];
    assign w_ay = i_s_axis_tdata[31:16];
    assign w_az = i_s_axis_tdata[47:32];

    logic                   r1_v;
    logic signed [SQ_W-1:0] r1_sx, r1_sy, r1_sz, r1_px, r1_py, r1_pz;
    logic [SQ_W-1:0]        r1_min_sq, r1_max_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sx     <= w_ax * w_ax;
            r1_sy     <= w_ay * w_ay;
            r1_sz     <= w_az * w_az;
            r1_px     <= w_ax * r_ref_x;
            r1_py     <= w_ay * r_ref_y;
            r1_pz     <= w_az * r_ref_z;
            r1_min_sq <= r_min_mag * r_min_mag;
            r1_max_sq <= r_max_mag * r_max_mag;
        end
    end

    // stage 2: sums and window test
    logic [SQ_W-1:0] n2_sum;
    t_root_side      n2_side;
    logic            r2_v;
    logic [SQ_W-1:0] r2_sum;
    t_root_side      r2_side;

    always_comb begin
        n2_sum      = unsigned'(r1_sx) + unsigned'(r1_sy) + unsigned'(r1_sz);
        n2_side.dot = DOT_W'(r1_px) + DOT_W'(r1_py) + DOT_W'(r1_pz);
        n2_side.ok  = (n2_sum >= r1_min_sq) && (n2_sum <= r1_max_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sum  <= n2_sum;
            r2_side <= n2_side;
        end
    end

    logic              w_rt_v;
    logic [ROOT_W-1:0] w_root;
    logic [RSW-1:0]    w_rt_side_bits;
    t_root_side        w_rt_side;

    tad_isqrt #(.SW(RSW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_rad   (r2_sum),
        .i_side  (r2_side),
        .o_valid (w_rt_v),
        .o_root  (w_root),
        .o_side  (w_rt_side_bits)
    );
    assign w_rt_side = w_rt_side_bits;

    // stage 3: rounding numerator 2|d| + m over 2m
    logic                r3_v;
    logic [N1W-1:0]      r3_num;
    logic [D1W-1:0]      r3_den;
    logic [2:0]          r3_side;
    logic [DOT_W-1:0]    n3_abs;

    assign n3_abs = w_rt_side.dot[DOT_W-1] ? (-w_rt_side.dot) : w_rt_side.dot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_num  <= {n3_abs[31:0], 1'b0} + N1W'(w_root);
            r3_den  <= {w_root, 1'b0};
            r3_side <= {w_rt_side.ok, (!w_rt_side.ok || w_root == '0),
                        w_rt_side.dot[DOT_W-1]};
        end
    end

    logic           w_d1_v, w_d1_ovf;
    logic [QW1-1:0] w_d1_q;
    logic [2:0]     w_d1_side;

    tad_div #(.NW(N1W), .DW(D1W), .QW(QW1), .SW(3)) u_div_align (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (w_d1_v),
        .o_quot  (w_d1_q),
        .o_ovf   (w_d1_ovf),
        .o_side  (w_d1_side)
    );

    // stage 4: saturate and sign the alignment
    logic [QW1-1:0]       n4_mag;
    logic signed [AW-1:0] n4_ext;
    logic                 r4_v, r4_ok;
    logic signed [AW-1:0] r4_align;

    always_comb begin
        n4_mag = (w_d1_ovf || w_d1_q > ONE_Q) ? ONE_Q : w_d1_q;
        n4_ext = {{(AW-QW1){1'b0}}, n4_mag};
        if (w_d1_side[1]) begin
            n4_ext = '0;
        end else if (w_d1_side[0]) begin
            n4_ext = -n4_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_align <= n4_ext;
            r4_ok    <= w_d1_side[2];
        end
    end

    // stage 5: offset from the minimum alignment
    logic signed [AW-1:0] w_min_a;
    logic                 r5_v, r5_ok, r5_act;
    logic signed [AW-1:0] r5_align;
    logic [AW-1:0]        r5_diff, r5_span;

    assign w_min_a = {{(AW-CFG_W){r_min_align[CFG_W-1]}}, r_min_align};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_ok    <= r4_ok;
            r5_align <= r4_align;
            r5_act   <= (r4_align >= w_min_a) && (w_min_a < ONE_A);
            r5_diff  <= r4_align - w_min_a;
            r5_span  <= ONE_A - w_min_a;
        end
    end

    // stage 6: scale to permille and form the rounding numerator
    logic [PW-1:0]  w_prod;
    logic           r6_v;
    logic [N2W-1:0] r6_num;
    logic [D2W-1:0] r6_den;
    logic [17:0]    r6_side;

    assign w_prod = PW'(r5_diff) * PW'(DUTY_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_num  <= {1'b0, w_prod, 1'b0} + N2W'(r5_span);
            r6_den  <= {r5_span, 1'b0};
            r6_side <= {r5_act, r5_ok, r5_align[15:0]};
        end
    end

    logic           w_d2_v, w_d2_ovf;
    logic [QW2-1:0] w_d2_q;
    logic [17:0]    w_d2_side;

    tad_div #(.NW(N2W), .DW(D2W), .QW(QW2), .SW(18)) u_div_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r6_v),
        .i_num   (r6_num),
        .i_den   (r6_den),
        .i_side  (r6_side),
        .o_valid (w_d2_v),
        .o_quot  (w_d2_q),
        .o_ovf   (w_d2_ovf),
        .o_side  (w_d2_side)
    );

    // output register: clamp the duty
    logic [DUTY_W-1:0] n_duty;
    logic [31:0]       r_out_data;

    always_comb begin
        n_duty = '0;
        if (w_d2_side[17]) begin
            n_duty = (w_d2_ovf || w_d2_q > DUTY_MAX) ? DUTY_MAX : w_d2_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {5'b0, w_d2_side[16], w_d2_side[15:0], n_duty};
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

    a_zero_align_out_of_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[26] |-> o_m_axis_tdata[25:10] == '0)
        else $error("alignment nonzero outside the magnitude window");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[9:0] <= DUTY_MAX)
        else $error("duty above full scale");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r1_v) && $stable(r6_v))
        else $error("pipeline moved during a stall");

endmodule

FILE: test/tb_top.sv
module tb_top;
    import tad_pkg::*;

    localparam int ONE_Q      = 1 << 14;
    localparam int LATENCY    = 50;
    localparam int WDOG_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_sample;

    typedef struct {
        logic [9:0]         duty;
        logic signed [15:0] align;
        logic               ok;
    } t_duty_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;

    // local copy of the configuration
    logic [15:0]        win_lo, win_hi;
    logic signed [15:0] dir_x, dir_y, dir_z, align_floor;

    t_sample   sample_q[$];
    t_duty_res expected_duty_q[$];
    int        n_errors = 0;
    int        idle_cycles = 0;
    bit        sink_enable = 1'b0;
    bit        stall_mode = 1'b0;

    // tready seen at the last rising edge, so the driver counts its transaction
    logic o_s_axis_tready_q = 1'b0;

    tilt_alignment_to_duty u_dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint floor_root(longint s);
        longint r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_duty_res tilt_to_duty(t_sample smp);
        t_duty_res res;
        longint x, y, z, s, m, d, mag, q, al, num, den, du;
        x = smp.ax; y = smp.ay; z = smp.az;
        s = x*x + y*y + z*z;
        res.ok = (s >= longint'(win_lo) * longint'(win_lo)) &&
                 (s <= longint'(win_hi) * longint'(win_hi));
        al = 0;
        du = 0;
        if (res.ok) begin
            m = floor_root(s);
            if (m != 0) begin
                d = x*dir_x + y*dir_y + z*dir_z;
                mag = d < 0 ? -d : d;
                q = (2*mag + m) / (2*m);
                if (q > ONE_Q) q = ONE_Q;
                al = d < 0 ? -q : q;
            end
        end
        if (al >= align_floor && align_floor < ONE_Q) begin
            num = (al - align_floor) * DUTY_SCALE;
            den = ONE_Q - align_floor;
            du = (2*num + den) / (2*den);
            if (du > DUTY_SCALE) du = DUTY_SCALE;
        end
        res.duty = du[9:0];
        res.align = al[15:0];
        return res;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready_q) begin
                expected_duty_q.push_back(tilt_to_duty(sample_q.pop_front()));
                src_gap = stall_mode ? gap_len() : 0;
            end
            if (src_gap > 0) begin
                src_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {sample_q[0].az, sample_q[0].ay, sample_q[0].ax};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
            if (!sink_enable) i_m_axis_tready <= 1'b0;
            else if (stall_mode) i_m_axis_tready <= ($urandom_range(0, 9) < 7);
            else i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) o_s_axis_tready_q <= o_s_axis_tready && i_s_axis_tvalid;

    // monitor
    always @(posedge i_clk) begin
        t_duty_res want;
        logic [9:0]  got_duty;
        logic [15:0] got_align;
        logic        got_ok;
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_duty  = o_m_axis_tdata[9:0];
                got_align = o_m_axis_tdata[25:10];
                got_ok    = o_m_axis_tdata[26];
                if (expected_duty_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result %h", o_m_axis_tdata);
                end else begin
                    want = expected_duty_q.pop_front();
                    if (got_duty !== want.duty || got_align !== want.align ||
                        got_ok !== want.ok || o_m_axis_tdata[31:27] !== 5'b0) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch: exp duty %0d align %0d ok %0b, ",
                                      "got duty %0d align %0d ok %0b"},
                                     want.duty, want.align, want.ok,
                                     got_duty, $signed(got_align), got_ok);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_MAG:   win_lo = val;
            CFG_MAX_MAG:   win_hi = val;
            CFG_REF_X:     dir_x = val;
            CFG_REF_Y:     dir_y = val;
            CFG_REF_Z:     dir_z = val;
            CFG_MIN_ALIGN: align_floor = val;
            default: ;
        endcase
    endtask

    task automatic add_sample(int x, int y, int z);
        t_sample smp;
        smp.ax = 16'(x); smp.ay = 16'(y); smp.az = 16'(z);
        sample_q.push_back(smp);
    endtask

    task automatic drain();
        wait (sample_q.size() == 0 && !i_s_axis_tvalid);
        wait (expected_duty_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int rand_unit();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return -16384;
        if (r == 1) return 16384;
        if (r == 2) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 32768) - 16384;
    endfunction

    task automatic random_samples(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0)
                add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768);
            else
                add_sample($urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000,
                           $urandom_range(0, 20000) - 4000);
        end
    endtask

    initial begin
        int ph;
        win_lo = MIN_MAG_RST; win_hi = MAX_MAG_RST;
        dir_x = REF_X_RST; dir_y = REF_Y_RST; dir_z = REF_Z_RST;
        align_floor = MIN_ALIGN_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        sink_enable = 1'b1;

        // directed: reset configuration
        add_sample(0, 0, 0);
        add_sample(0, 0, 16384);
        add_sample(0, 0, -16384);
        add_sample(32767, 32767, 32767);
        add_sample(-32768, -32768, -32768);
        add_sample(16384, 0, 15000);
        add_sample(0, 16384, 0);
        add_sample(1, -1, 1);
        drain();

        // narrow window, oversized reference, negative floor
        write_reg(CFG_MIN_MAG, 16'd1000);
        write_reg(CFG_MAX_MAG, 16'd20000);
        write_reg(CFG_REF_X, 16'h7FFF);
        write_reg(CFG_REF_Y, 16'h8000);
        write_reg(CFG_REF_Z, 16'd0);
        write_reg(CFG_MIN_ALIGN, -16'sd16384);
        add_sample(999, 0, 0);
        add_sample(1000, 0, 0);
        add_sample(20000, 0, 0);
        add_sample(20001, 0, 0);
        add_sample(5000, 0, 0);
        add_sample(0, 5000, 0);
        add_sample(3000, 3000, 0);
        drain();

        // inverted window and full-scale floor
        write_reg(CFG_MIN_MAG, 16'hFFFF);
        write_reg(CFG_MAX_MAG, 16'd0);
        write_reg(CFG_MIN_ALIGN, 16'd16384);
        add_sample(0, 0, 0);
        add_sample(100, 200, 300);
        add_sample(-32768, 32767, 0);
        drain();
        write_reg(CFG_MIN_ALIGN, 16'h7FFF);
        add_sample(5, 5, 5);
        drain();

        // random phases with changing settings, stalls on in every phase but ph == 3
        stall_mode = 1'b1;
        for (ph = 0; ph < 6; ph++) begin
            write_reg(CFG_MIN_MAG, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 3000)));
            write_reg(CFG_MAX_MAG, (ph == 1) ? 16'hFFFF : (ph == 0 ? 16'd56756 :
                      16'($urandom_range(4000, 60000))));
            write_reg(CFG_REF_X, 16'(rand_unit()));
            write_reg(CFG_REF_Y, 16'(rand_unit()));
            write_reg(CFG_REF_Z, 16'(rand_unit()));
            write_reg(CFG_MIN_ALIGN, (ph == 2) ? -16'sd16384 : 16'(rand_unit()));
            stall_mode = (ph != 3);
            random_samples(95);
            drain();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        if (n_errors == 0 && expected_duty_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
